// ===== rtl/core/urc_pkg.sv =====
// Shared types and constants for the ultrasonic range controller.
// No dependencies; every other file of the block imports this package.
package urc_pkg;

  localparam int TimeW   = 32;
  localparam int PeriodW = 24;
  localparam int WidthW  = 10;
  localparam int EchoW   = 16;
  localparam int DistW   = 14;
  localparam int CfgIdxW = 8;
  localparam int CfgDatW = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_PERIOD = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_TRIGGER_WIDTH  = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_ECHO       = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_MAX_ECHO       = 8'd3;

  localparam logic [PeriodW-1:0] PeriodRst  = 24'd60000;
  localparam logic [WidthW-1:0]  WidthRst   = 10'd20;
  localparam logic [EchoW-1:0]   MinEchoRst = 16'd10;
  localparam logic [EchoW-1:0]   MaxEchoRst = 16'd50000;
  localparam logic [TimeW-1:0]   ReleaseRst = 32'd11;
  localparam logic [DistW-1:0]   DistRst    = 14'd10000;

  // Millimetres = us * 343 / 2000, done as one multiply by a 2^-32 scaled
  // reciprocal. Rounding the factor up keeps the floor exact for all
  // 16-bit high times.
  localparam longint unsigned MmNum   = 343;
  localparam longint unsigned MmDen   = 2000;
  localparam int              MmShift = 32;
  localparam longint unsigned MmScaleL = ((MmNum << MmShift) + MmDen - 1) / MmDen;
  localparam int              MmScaleW = 30;
  localparam logic [MmScaleW-1:0] MmScale = MmScaleL[MmScaleW-1:0];

  typedef struct packed {
    logic [PeriodW-1:0] trigger_period;
    logic [WidthW-1:0]  trigger_width;
    logic [EchoW-1:0]   min_echo;
    logic [EchoW-1:0]   max_echo;
  } cfg_t;

  typedef struct packed {
    logic             echo_seen;
    logic             done;
    logic             glitch;
    logic [DistW-1:0] distance;
  } echo_res_t;

endpackage

// ===== rtl/core/urc_if.sv =====
// Handshake channels of the ultrasonic range controller: tick input,
// result output and configuration write. Depends on urc_pkg.
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;
  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urc_out_if import urc_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             trigger_level;
  logic [DistW-1:0] distance_mm;
  logic             measure_done;
  logic             glitch;
  modport source (output valid, output trigger_level, output distance_mm,
                  output measure_done, output glitch, input ready);
  modport sink (input valid, input trigger_level, input distance_mm,
                input measure_done, input glitch, output ready);
endinterface

interface urc_cfg_if import urc_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/urc_echo.sv =====
// Echo edge stamping, glitch window and millimetre conversion.
// Depends on urc_pkg for the result struct and the scale constant.
module urc_echo import urc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             echo_level,
  input  logic [TimeW-1:0] time_now,
  input  cfg_t             cfg,
  output echo_res_t        res
);

  logic             echo_prev_r, echo_prev_nxt;
  logic [TimeW-1:0] rise_r, rise_nxt;
  logic [TimeW-1:0] fall_r, fall_nxt;
  logic [TimeW-1:0] handled_r, handled_nxt;
  logic [DistW-1:0] dist_r, dist_nxt;
  logic [TimeW-1:0] high_time;
  logic [EchoW+MmScaleW-1:0] mm_prod;
  logic             seen, in_window;

  always_comb begin
    rise_nxt = (echo_level && !echo_prev_r) ? time_now : rise_r;
    fall_nxt = (!echo_level && echo_prev_r) ? time_now : fall_r;
    echo_prev_nxt = echo_level;
    seen = (fall_nxt != handled_r);
    high_time = fall_nxt - rise_nxt;
    in_window = (high_time <= {{(TimeW-EchoW){1'b0}}, cfg.max_echo}) &&
                (high_time >= {{(TimeW-EchoW){1'b0}}, cfg.min_echo});
    // Only used when the high time is inside the window, so 16 bits suffice.
    mm_prod = {{MmScaleW{1'b0}}, high_time[EchoW-1:0]} * {{EchoW{1'b0}}, MmScale};
    handled_nxt = seen ? fall_nxt : handled_r;
    dist_nxt = (seen && in_window) ? mm_prod[MmShift +: DistW] : dist_r;
    res.echo_seen = seen;
    res.done = seen && in_window;
    res.glitch = seen && !in_window;
    res.distance = dist_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_prev_r <= 1'b0;
      rise_r <= '0;
      fall_r <= '0;
      handled_r <= '0;
      dist_r <= DistRst;
    end else if (step) begin
      echo_prev_r <= echo_prev_nxt;
      rise_r <= rise_nxt;
      fall_r <= fall_nxt;
      handled_r <= handled_nxt;
      dist_r <= dist_nxt;
    end
  end

  a_dist_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !res.done) |=> dist_r == $past(dist_r))
    else $error("distance changed without an accepted echo");

  a_handled_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> handled_r == fall_r)
    else $error("handled stamp lags the fall stamp");

endmodule

// ===== rtl/core/urc_trigger.sv =====
// Free-running microsecond counter and periodic trigger pulse generator
// with wrap-safe deadlines. Depends on urc_pkg.
module urc_trigger import urc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic             skip,
  input  cfg_t             cfg,
  output logic [TimeW-1:0] time_now,
  output logic             trigger_nxt
);

  logic [TimeW-1:0] time_r, fire_r, fire_nxt, rel_r, rel_nxt;
  logic [TimeW-1:0] fire_diff, rel_diff;
  logic             trig_r, fire_hit, rel_hit;

  assign time_now = time_r;

  always_comb begin
    // A deadline has passed when now - due lies in the lower half, excluding zero.
    fire_diff = time_r - fire_r;
    rel_diff  = time_r - rel_r;
    fire_hit = !skip && (fire_diff != '0) && !fire_diff[TimeW-1];
    rel_hit  = !skip && (rel_diff != '0) && !rel_diff[TimeW-1];
    fire_nxt = fire_hit ? time_r + {{(TimeW-PeriodW){1'b0}}, cfg.trigger_period} : fire_r;
    rel_nxt  = rel_hit ? fire_nxt + {{(TimeW-WidthW){1'b0}}, cfg.trigger_width} : rel_r;
    if (rel_hit) begin
      trigger_nxt = 1'b0;
    end else if (fire_hit) begin
      trigger_nxt = 1'b1;
    end else begin
      trigger_nxt = trig_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
      fire_r <= '0;
      rel_r <= ReleaseRst;
      trig_r <= 1'b0;
    end else if (step) begin
      time_r <= time_r + TimeW'(1);
      fire_r <= fire_nxt;
      rel_r <= rel_nxt;
      trig_r <= trigger_nxt;
    end
  end

  a_time_counts: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> time_r == $past(time_r) + TimeW'(1))
    else $error("time counter did not advance on a tick");

  a_skip_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (step && skip) |=> (fire_r == $past(fire_r)) && (rel_r == $past(rel_r)))
    else $error("trigger deadlines moved on an echo tick");

endmodule

// ===== rtl/core/ultrasonic_range_controller_unit.sv =====
// Ultrasonic range controller top level: configuration registers, tick
// handshake and result register. Depends on urc_pkg, urc_if, urc_echo, urc_trigger.
//
// Each input item is one microsecond tick carrying the sampled echo level; each
// item yields exactly one result in the following cycle (trigger level, held
// distance in millimetres, done and glitch flags). One item is taken per clock: the
// whole tick update, including the single 16x30 multiply for the distance, lies
// between the state registers and the result register, and a new item is accepted
// while the result register is empty or being drained in the same cycle.
// Configuration writes are always ready; unknown indexes are ignored.
module ultrasonic_range_controller_unit import urc_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  urc_in_if.sink      in_chan,
  urc_out_if.source   out_chan,
  urc_cfg_if.sink     cfg_chan
);

  cfg_t             cfg_r;
  echo_res_t        echo_res;
  logic [TimeW-1:0] time_now;
  logic             trigger_nxt, in_acc;
  logic             out_valid_r, out_valid_nxt;
  logic             trig_q_r, done_q_r, glitch_q_r;
  logic [DistW-1:0] dist_q_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_period <= PeriodRst;
      cfg_r.trigger_width <= WidthRst;
      cfg_r.min_echo <= MinEchoRst;
      cfg_r.max_echo <= MaxEchoRst;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_TRIGGER_PERIOD: cfg_r.trigger_period <= cfg_chan.data[PeriodW-1:0];
        REG_TRIGGER_WIDTH:  cfg_r.trigger_width <= cfg_chan.data[WidthW-1:0];
        REG_MIN_ECHO:       cfg_r.min_echo <= cfg_chan.data[EchoW-1:0];
        REG_MAX_ECHO:       cfg_r.max_echo <= cfg_chan.data[EchoW-1:0];
        default: ;
      endcase
    end
  end

  urc_echo u_echo (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .echo_level (in_chan.echo_level),
    .time_now   (time_now),
    .cfg        (cfg_r),
    .res        (echo_res)
  );

  urc_trigger u_trigger (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .skip        (echo_res.echo_seen),
    .cfg         (cfg_r),
    .time_now    (time_now),
    .trigger_nxt (trigger_nxt)
  );

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      trig_q_r <= trigger_nxt;
      dist_q_r <= echo_res.distance;
      done_q_r <= echo_res.done;
      glitch_q_r <= echo_res.glitch;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.trigger_level = trig_q_r;
  assign out_chan.distance_mm = dist_q_r;
  assign out_chan.measure_done = done_q_r;
  assign out_chan.glitch = glitch_q_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(done_q_r && glitch_q_r))
    else $error("result flags both done and glitch");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |=> out_valid_r && $stable(dist_q_r))
    else $error("pending result was lost");

endmodule

// ===== test/ultrasonic_range_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_range_controller_unit: echo pulse stimulus,
// per-tick prediction of trigger, distance and flags, random idling on both sides.
// Depends on urc_pkg, urc_if and the RTL of the block.
module ultrasonic_range_controller_unit_tb import urc_pkg::*; ;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [CfgIdxW-1:0] REG_SPARE = 8'd200;

  localparam longint unsigned MM_NUM = 343;
  localparam longint unsigned MM_DEN = 2000;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_HEAVY} idle_mode_t;

  typedef struct packed {
    logic             trigger;
    logic [DistW-1:0] distance;
    logic             done;
    logic             glitch;
  } reading_t;

  class echo_ranging_board;
    logic [PeriodW-1:0] period;
    logic [WidthW-1:0]  width;
    logic [EchoW-1:0]   min_echo;
    logic [EchoW-1:0]   max_echo;
    logic [TimeW-1:0]   now;
    logic [TimeW-1:0]   rise_t;
    logic [TimeW-1:0]   fall_t;
    logic [TimeW-1:0]   handled_fall_t;
    logic [TimeW-1:0]   fire_at;
    logic [TimeW-1:0]   release_at;
    logic               echo_last;
    logic               trig;
    logic [DistW-1:0]   held_dist;
    reading_t           readings[$];
    int                 errors;
    int                 checked;

    function new();
      period         = 24'd60000;
      width          = 10'd20;
      min_echo       = 16'd10;
      max_echo       = 16'd50000;
      now            = '0;
      rise_t         = '0;
      fall_t         = '0;
      handled_fall_t = '0;
      fire_at        = '0;
      release_at     = 32'd11;
      echo_last      = 1'b0;
      trig           = 1'b0;
      held_dist      = 14'd10000;
      errors         = 0;
      checked        = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] data);
      case (idx)
        REG_TRIGGER_PERIOD: period = data[PeriodW-1:0];
        REG_TRIGGER_WIDTH:  width = data[WidthW-1:0];
        REG_MIN_ECHO:       min_echo = data[EchoW-1:0];
        REG_MAX_ECHO:       max_echo = data[EchoW-1:0];
        default: ;
      endcase
    endfunction

    // A deadline counts as passed when now is ahead of it by less than half the wrap.
    function bit deadline_hit(logic [TimeW-1:0] t, logic [TimeW-1:0] due);
      logic [TimeW-1:0] d;
      d = t - due;
      return (d != '0) && !d[TimeW-1];
    endfunction

    function void take_tick(logic echo);
      logic [TimeW-1:0] t;
      logic [TimeW-1:0] high_t;
      longint unsigned  mm;
      reading_t         r;
      t = now;
      r.done = 1'b0;
      r.glitch = 1'b0;
      if (echo && !echo_last) rise_t = t;
      if (!echo && echo_last) fall_t = t;
      echo_last = echo;
      if (fall_t != handled_fall_t) begin
        // Echo handling takes the whole tick; the trigger logic waits.
        high_t = fall_t - rise_t;
        handled_fall_t = fall_t;
        if (high_t > TimeW'(max_echo) || high_t < TimeW'(min_echo)) begin
          r.glitch = 1'b1;
        end else begin
          mm = {32'd0, high_t} * MM_NUM / MM_DEN;
          held_dist = mm[DistW-1:0];
          r.done = 1'b1;
        end
      end else begin
        if (deadline_hit(t, fire_at)) begin
          fire_at = t + TimeW'(period);
          trig = 1'b1;
        end
        if (deadline_hit(t, release_at)) begin
          release_at = fire_at + TimeW'(width);
          trig = 1'b0;
        end
      end
      now = t + 1;
      r.trigger = trig;
      r.distance = held_dist;
      readings.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task match_reading(logic trigger, logic [DistW-1:0] distance, logic done, logic glitch);
      reading_t w;
      checked++;
      if (readings.size() == 0) begin
        report("result item with no tick waiting");
      end else begin
        w = readings.pop_front();
        if (trigger !== w.trigger)
          report($sformatf("trigger_level got %b want %b", trigger, w.trigger));
        if (distance !== w.distance)
          report($sformatf("distance_mm got %0d want %0d", distance, w.distance));
        if (done !== w.done)
          report($sformatf("measure_done got %b want %b", done, w.done));
        if (glitch !== w.glitch)
          report($sformatf("glitch got %b want %b", glitch, w.glitch));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  urc_in_if  in_chan();
  urc_out_if out_chan();
  urc_cfg_if cfg_chan();

  ultrasonic_range_controller_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  echo_ranging_board board;
  idle_mode_t        idle_mode;
  bit                hold_req;
  int                sent_items;
  int                cycles;
  int                cur_min;
  int                cur_max;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ultrasonic_range_controller_unit_tb: FAIL");
      $finish;
    end
  end

  // Ticks are noted before results are checked, so the order holds at any latency.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_chan.valid && cfg_chan.ready) board.write_reg(cfg_chan.index, cfg_chan.data);
      if (in_chan.valid && in_chan.ready) board.take_tick(in_chan.echo_level);
      if (out_chan.valid && out_chan.ready)
        board.match_reading(out_chan.trigger_level, out_chan.distance_mm,
                            out_chan.measure_done, out_chan.glitch);
    end
  end

  function automatic int idle_gap();
    case (idle_mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      default:   return $urandom_range(0, 19);
    endcase
  endfunction

  // Receiver: stalls per item, and holds off for a long stretch when asked.
  initial begin
    int gap;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = hold_req ? HOLD_CYCLES : idle_gap();
      hold_req = 1'b0;
      if (gap > 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!out_chan.valid);
    end
  end

  // Valid stays high from one item to the next when there is no gap.
  task automatic send_tick(input logic echo);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      in_chan.echo_level <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.echo_level <= echo;
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
  endtask

  task automatic wait_drained();
    while (board.checked < sent_items) @(posedge clk);
  endtask

  task automatic set_config(input logic [PeriodW-1:0] p, input logic [WidthW-1:0] w,
                            input logic [EchoW-1:0] lo, input logic [EchoW-1:0] hi);
    logic [CfgIdxW-1:0] idx [5];
    logic [CfgDatW-1:0] dat [5];
    logic [31:0]        junk;
    junk = $urandom();
    idx = '{REG_TRIGGER_PERIOD, REG_TRIGGER_WIDTH, REG_MIN_ECHO, REG_MAX_ECHO, REG_SPARE};
    // Upper bits beyond the width of the narrower registers carry junk that must be dropped.
    dat[0] = p;
    dat[1] = {junk[13:0], w};
    dat[2] = {junk[7:0], lo};
    dat[3] = {junk[15:8], hi};
    dat[4] = junk[23:0];
    for (int i = 0; i < 5; i++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= idx[i];
      cfg_chan.data <= dat[i];
      do @(posedge clk); while (!cfg_chan.ready);
    end
    cfg_chan.valid <= 1'b0;
    cur_min = int'(lo);
    cur_max = int'(hi);
  endtask

  // One echo burst: a low stretch, then mostly a pulse inside the window,
  // sometimes one just outside it, sometimes random noise.
  task automatic send_burst();
    int kind;
    int lo;
    int hi;
    int len;
    kind = $urandom_range(0, 99);
    lo = (cur_min == 0) ? 1 : cur_min;
    hi = (cur_max < lo + 60) ? cur_max : lo + 60;
    if ($urandom_range(0, 19) == 0 && cur_max > hi) hi = (cur_max > lo + 800) ? lo + 800 : cur_max;
    repeat ($urandom_range(1, 8)) send_tick(1'b0);
    if (kind < 70 && lo <= hi && lo <= 1000) begin
      len = $urandom_range(lo, hi);
      if ($urandom_range(0, 7) == 0) len = lo;
      else if ($urandom_range(0, 7) == 0) len = hi;
      repeat (len) send_tick(1'b1);
    end else if (kind < 85) begin
      if (cur_min > 1 && cur_min <= 1000 && $urandom_range(0, 1) == 1) len = cur_min - 1;
      else if (cur_max < 200) len = cur_max + 1;
      else len = $urandom_range(1, 3);
      repeat (len) send_tick(1'b1);
    end else begin
      repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input logic [PeriodW-1:0] p, input logic [WidthW-1:0] w,
                           input logic [EchoW-1:0] lo, input logic [EchoW-1:0] hi,
                           input idle_mode_t mode, input bit pressure, input int n);
    int target;
    set_config(p, w, lo, hi);
    idle_mode = mode;
    if (pressure) hold_req = 1'b1;
    target = sent_items + n;
    while (sent_items < target) send_burst();
    in_chan.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    logic [EchoW-1:0] lo;
    board = new();
    cycles = 0;
    sent_items = 0;
    hold_req = 1'b0;
    idle_mode = IDLE_NONE;
    cur_min = 10;
    cur_max = 50000;
    rst_n <= 1'b0;
    in_chan.valid <= 1'b0;
    in_chan.echo_level <= 1'b0;
    cfg_chan.valid <= 1'b0;
    cfg_chan.index <= '0;
    cfg_chan.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // At reset values: an echo rising at time zero and accepted, then a short
    // glitch. The first fall lands on the tick where the trigger would release.
    repeat (12) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    repeat (2) send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    in_chan.valid <= 1'b0;
    wait_drained();

    run_phase(24'd40, 10'd5, 16'd3, 16'd60, IDLE_SOME, 1'b1, 200);
    // Empty window at zero: every echo is rejected.
    run_phase(24'd1, 10'd1, 16'd0, 16'd0, IDLE_HEAVY, 1'b0, 120);
    // Zero period and width fire and release on nearly every tick.
    run_phase(24'd0, 10'd0, 16'd0, 16'd65535, IDLE_NONE, 1'b0, 150);
    run_phase(24'hFFFFFF, 10'h3FF, 16'hFFFF, 16'hFFFF, IDLE_SOME, 1'b0, 120);
    // Inverted window.
    run_phase(24'd25, 10'h3FF, 16'd50, 16'd10, IDLE_HEAVY, 1'b0, 120);
    run_phase(24'd200, 10'd17, 16'd5, 16'd400, IDLE_HEAVY, 1'b1, 300);
    repeat (3) begin
      lo = EchoW'($urandom_range(0, 20));
      run_phase(PeriodW'($urandom_range(1, 300)), WidthW'($urandom_range(1, 50)), lo,
                EchoW'($urandom_range(lo, 500)), idle_mode_t'($urandom_range(0, 2)),
                1'($urandom_range(0, 1)), 150);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.readings.size() == 0) begin
      $display("ultrasonic_range_controller_unit_tb: PASS");
    end else begin
      $display("ultrasonic_range_controller_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
